/* rtl/rccs_pkg.sv */
// Shared constants, types and helpers of the channel calibrated scaler.
package rccs_pkg;

	localparam int CHANNELS = 8;
	localparam int KIND_W   = 2;
	localparam int CH_W     = 3;
	localparam int PULSE_W  = 12;
	localparam int VAL_W    = 16;

	localparam logic [KIND_W-1:0] KIND_SAMPLE = 2'd0;
	localparam logic [KIND_W-1:0] KIND_CAL    = 2'd1;
	localparam logic [KIND_W-1:0] KIND_BEGIN  = 2'd2;
	localparam logic [KIND_W-1:0] KIND_LOAD   = 2'd3;

	localparam logic [PULSE_W-1:0] CAL_LOW_START  = 12'd3000;
	localparam logic [PULSE_W-1:0] CAL_HIGH_START = 12'd0;

	localparam int OUT_SPAN = 1000;
	localparam int OUT_MIN  = -500;

	// |raw - low| * 1000 stays below 2**22
	localparam int NUM_W     = 22;
	localparam int DIG_W     = 2;
	localparam int DIV_STEPS = NUM_W / DIG_W;
	localparam int CNT_W     = $clog2(DIV_STEPS);

	typedef struct packed {
		logic                 we;
		logic [KIND_W-1:0]    kind;
		logic [CH_W-1:0]      ch;
		logic [PULSE_W-1:0]   raw;
		logic [PULSE_W-1:0]   ld_lo;
		logic [PULSE_W-1:0]   ld_hi;
	} bank_cmd_t;

	typedef struct packed {
		logic [PULSE_W-1:0] old_lo;
		logic [PULSE_W-1:0] old_hi;
		logic [PULSE_W-1:0] new_lo;
		logic [PULSE_W-1:0] new_hi;
	} bank_rd_t;

	typedef struct packed {
		logic               start;
		logic [NUM_W-1:0]   dividend;
		logic [PULSE_W-1:0] divisor;
	} div_req_t;

	typedef struct packed {
		logic             busy;
		logic             done;
		logic [NUM_W-1:0] quot;
	} div_rsp_t;

	function automatic logic chan_ok(input logic [CH_W-1:0] ch);
		return 32'(ch) < CHANNELS;
	endfunction

endpackage

/* rtl/rccs_in_if.sv */
// Request channel carrying one input item.
interface rccs_in_if;
	logic                           valid;
	logic                           ready;
	logic [rccs_pkg::KIND_W-1:0]    kind;
	logic [rccs_pkg::CH_W-1:0]      channel;
	logic [rccs_pkg::PULSE_W-1:0]   raw_pulse;
	logic [rccs_pkg::PULSE_W-1:0]   load_low;
	logic [rccs_pkg::PULSE_W-1:0]   load_high;

	modport source (output valid, kind, channel, raw_pulse, load_low, load_high, input ready);
	modport sink (input valid, kind, channel, raw_pulse, load_low, load_high, output ready);
endinterface

/* rtl/rccs_out_if.sv */
// Result channel carrying one mapped result.
interface rccs_out_if;
	logic                           valid;
	logic                           ready;
	logic [rccs_pkg::CH_W-1:0]      out_channel;
	logic signed [rccs_pkg::VAL_W-1:0] scaled_value;
	logic                           saturated;
	logic                           bounds_error;
	logic [rccs_pkg::PULSE_W-1:0]   bound_low;
	logic [rccs_pkg::PULSE_W-1:0]   bound_high;

	modport source (output valid, out_channel, scaled_value, saturated, bounds_error,
		bound_low, bound_high, input ready);
	modport sink (input valid, out_channel, scaled_value, saturated, bounds_error,
		bound_low, bound_high, output ready);
endinterface

/* rtl/rc_channel_calibrated_scaler_top.sv */
// Top level of the channel calibrated scaler.
// Maps a raw pulse onto -500..500 as (raw-low)*1000/(high-low)-500 with the
// channel's calibrated bounds, truncating toward zero, saturating to 16 bits.
// One request at a time: an accepted sample or calibration sample passes
// through the multiply state (product formed, two-bit-per-cycle divider
// started), the divide state until the divider reports done, and the done
// state for offset and saturation; begin calibration, load and equal-bounds
// requests go from multiply straight to done. The done state waits for a
// free output register; the input is ready again once the result is loaded.
// A new request is taken while the previous result still waits in the
// output register.
module rc_channel_calibrated_scaler_top (
	input  logic         clk,
	input  logic         arst_n,
	rccs_in_if.sink      sample,
	rccs_out_if.source   result
);

	localparam logic [1:0] S_IDLE = 2'd0;
	localparam logic [1:0] S_MUL  = 2'd1;
	localparam logic [1:0] S_DIV  = 2'd2;
	localparam logic [1:0] S_DONE = 2'd3;

	logic [1:0]                         state_q;
	logic                               acc;
	logic [rccs_pkg::KIND_W-1:0]        kind_q;
	logic [rccs_pkg::CH_W-1:0]          ch_q;
	logic                               ok_q;
	logic [rccs_pkg::PULSE_W-1:0]       raw_q;
	logic [rccs_pkg::PULSE_W-1:0]       olo_q;
	logic [rccs_pkg::PULSE_W-1:0]       ohi_q;
	logic [rccs_pkg::PULSE_W-1:0]       nlo_q;
	logic [rccs_pkg::PULSE_W-1:0]       nhi_q;
	logic                               neg_q;
	logic                               err_q;
	logic                               used_q;

	rccs_pkg::bank_cmd_t                bank_cmd;
	rccs_pkg::bank_rd_t                 bank_rd;
	rccs_pkg::div_req_t                 div_req;
	rccs_pkg::div_rsp_t                 div_rsp;

	logic signed [rccs_pkg::PULSE_W:0]  diff;
	logic signed [rccs_pkg::PULSE_W:0]  den;
	logic [rccs_pkg::PULSE_W-1:0]       diff_mag;
	logic [rccs_pkg::PULSE_W-1:0]       den_mag;
	logic                               is_map;
	logic                               den_zero;

	logic signed [rccs_pkg::NUM_W+1:0]  sq;
	logic signed [rccs_pkg::NUM_W+1:0]  v;
	logic signed [rccs_pkg::VAL_W-1:0]  v_sat;
	logic                               v_clip;
	logic                               out_free;

	logic                               out_vld_q;
	logic [rccs_pkg::CH_W-1:0]          out_ch_q;
	logic signed [rccs_pkg::VAL_W-1:0]  out_val_q;
	logic                               out_sat_q;
	logic                               out_err_q;
	logic [rccs_pkg::PULSE_W-1:0]       out_lo_q;
	logic [rccs_pkg::PULSE_W-1:0]       out_hi_q;

	assign sample.ready = (state_q == S_IDLE);
	assign acc          = sample.valid && sample.ready;

	assign bank_cmd.we    = acc && rccs_pkg::chan_ok(sample.channel);
	assign bank_cmd.kind  = sample.kind;
	assign bank_cmd.ch    = sample.channel;
	assign bank_cmd.raw   = sample.raw_pulse;
	assign bank_cmd.ld_lo = sample.load_low;
	assign bank_cmd.ld_hi = sample.load_high;

	rccs_bank u_bank (
		.clk    (clk),
		.arst_n (arst_n),
		.cmd    (bank_cmd),
		.rd     (bank_rd)
	);

	always_comb begin
		diff     = $signed({1'b0, raw_q}) - $signed({1'b0, olo_q});
		den      = $signed({1'b0, ohi_q}) - $signed({1'b0, olo_q});
		diff_mag = diff[rccs_pkg::PULSE_W] ? rccs_pkg::PULSE_W'(-diff)
			: diff[rccs_pkg::PULSE_W-1:0];
		den_mag  = den[rccs_pkg::PULSE_W] ? rccs_pkg::PULSE_W'(-den)
			: den[rccs_pkg::PULSE_W-1:0];
		den_zero = (den == '0);
		is_map   = ok_q && (kind_q == rccs_pkg::KIND_SAMPLE || kind_q == rccs_pkg::KIND_CAL);
	end

	assign div_req.start    = (state_q == S_MUL) && is_map && !den_zero;
	assign div_req.dividend = rccs_pkg::NUM_W'(diff_mag) * rccs_pkg::NUM_W'(rccs_pkg::OUT_SPAN);
	assign div_req.divisor  = den_mag;

	rccs_div u_div (
		.clk    (clk),
		.arst_n (arst_n),
		.req    (div_req),
		.rsp    (div_rsp)
	);

	always_comb begin
		sq = $signed({2'b00, div_rsp.quot});
		if (neg_q)
			sq = -sq;
		v = sq + (rccs_pkg::NUM_W + 2)'(rccs_pkg::OUT_MIN);
		v_clip = 1'b0;
		v_sat  = v[rccs_pkg::VAL_W-1:0];
		if (v > (rccs_pkg::NUM_W + 2)'(32767)) begin
			v_sat  = 16'sh7fff;
			v_clip = 1'b1;
		end else if (v < -(rccs_pkg::NUM_W + 2)'(32768)) begin
			v_sat  = 16'sh8000;
			v_clip = 1'b1;
		end
	end

	assign out_free = !out_vld_q || result.ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: if (acc) state_q <= S_MUL;
				S_MUL:  state_q <= div_req.start ? S_DIV : S_DONE;
				S_DIV:  if (div_rsp.done) state_q <= S_DONE;
				S_DONE: if (out_free) state_q <= S_IDLE;
				default: state_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (acc) begin
			kind_q <= sample.kind;
			ch_q   <= sample.channel;
			ok_q   <= rccs_pkg::chan_ok(sample.channel);
			raw_q  <= sample.raw_pulse;
			olo_q  <= bank_rd.old_lo;
			ohi_q  <= bank_rd.old_hi;
			nlo_q  <= bank_rd.new_lo;
			nhi_q  <= bank_rd.new_hi;
		end
		if (state_q == S_MUL) begin
			neg_q  <= diff[rccs_pkg::PULSE_W] ^ den[rccs_pkg::PULSE_W];
			err_q  <= is_map && den_zero;
			used_q <= div_req.start;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_vld_q <= 1'b0;
		end else if (state_q == S_DONE && out_free) begin
			out_vld_q <= 1'b1;
		end else if (result.ready) begin
			out_vld_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == S_DONE && out_free) begin
			out_ch_q  <= ch_q;
			out_val_q <= used_q ? v_sat : '0;
			out_sat_q <= used_q && v_clip;
			out_err_q <= err_q;
			out_lo_q  <= ok_q ? nlo_q : '0;
			out_hi_q  <= ok_q ? nhi_q : '0;
		end
	end

	assign result.valid        = out_vld_q;
	assign result.out_channel  = out_ch_q;
	assign result.scaled_value = out_val_q;
	assign result.saturated    = out_sat_q;
	assign result.bounds_error = out_err_q;
	assign result.bound_low    = out_lo_q;
	assign result.bound_high   = out_hi_q;

`ifndef SYNTHESIS
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.bounds_error |-> result.scaled_value == '0 && !result.saturated)
		else $error("bounds error result with nonzero value");

	a_sat_rail: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && result.saturated |->
			(result.scaled_value == 16'sh7fff || result.scaled_value == 16'sh8000))
		else $error("saturated result not at a rail");

	a_div_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_rsp.busy |-> state_q == S_DIV)
		else $error("divider busy outside divide state");

	a_accept_mul: assert property (@(posedge clk) disable iff (!arst_n)
		acc |=> state_q == S_MUL)
		else $error("accepted request did not enter multiply");
`endif

endmodule

/* rtl/rccs_div.sv */
// Radix-4 restoring divider on magnitudes, two quotient bits per cycle.
module rccs_div (
	input  logic                clk,
	input  logic                arst_n,
	input  rccs_pkg::div_req_t  req,
	output rccs_pkg::div_rsp_t  rsp
);

	logic                             busy_q;
	logic                             done_q;
	logic [rccs_pkg::CNT_W-1:0]       cnt_q;
	logic [rccs_pkg::NUM_W-1:0]       sh_q;
	logic [rccs_pkg::PULSE_W-1:0]     rem_q;
	logic [rccs_pkg::PULSE_W-1:0]     dvs_q;
	logic [rccs_pkg::NUM_W-1:0]       sh_d;
	logic [rccs_pkg::PULSE_W-1:0]     rem_d;

	always_comb begin
		logic [rccs_pkg::PULSE_W:0] t;
		rem_d = rem_q;
		sh_d  = sh_q;
		for (int i = 0; i < rccs_pkg::DIG_W; i++) begin
			t    = {rem_d, sh_d[rccs_pkg::NUM_W-1]};
			sh_d = {sh_d[rccs_pkg::NUM_W-2:0], 1'b0};
			if (t >= {1'b0, dvs_q}) begin
				t       = t - {1'b0, dvs_q};
				sh_d[0] = 1'b1;
			end
			rem_d = t[rccs_pkg::PULSE_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == rccs_pkg::CNT_W'(rccs_pkg::DIV_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			sh_q  <= req.dividend;
			rem_q <= '0;
			dvs_q <= req.divisor;
		end else if (busy_q) begin
			sh_q  <= sh_d;
			rem_q <= rem_d;
		end
	end

	assign rsp.busy = busy_q;
	assign rsp.done = done_q;
	assign rsp.quot = sh_q;

endmodule

/* rtl/rccs_bank.sv */
// Per-channel calibrated low and high bounds with their update rules.
module rccs_bank (
	input  logic                 clk,
	input  logic                 arst_n,
	input  rccs_pkg::bank_cmd_t  cmd,
	output rccs_pkg::bank_rd_t   rd
);

	logic [rccs_pkg::PULSE_W-1:0] low_q  [rccs_pkg::CHANNELS];
	logic [rccs_pkg::PULSE_W-1:0] high_q [rccs_pkg::CHANNELS];

	always_comb begin
		rd.old_lo = low_q[cmd.ch];
		rd.old_hi = high_q[cmd.ch];
		rd.new_lo = rd.old_lo;
		rd.new_hi = rd.old_hi;
		case (cmd.kind)
			rccs_pkg::KIND_CAL: begin
				if (cmd.raw > rd.old_hi)
					rd.new_hi = cmd.raw;
				if (cmd.raw < rd.old_lo)
					rd.new_lo = cmd.raw;
			end
			rccs_pkg::KIND_BEGIN: begin
				rd.new_lo = rccs_pkg::CAL_LOW_START;
				rd.new_hi = rccs_pkg::CAL_HIGH_START;
			end
			rccs_pkg::KIND_LOAD: begin
				rd.new_lo = cmd.ld_lo;
				rd.new_hi = cmd.ld_hi;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < rccs_pkg::CHANNELS; i++) begin
				low_q[i]  <= rccs_pkg::CAL_LOW_START;
				high_q[i] <= rccs_pkg::CAL_HIGH_START;
			end
		end else if (cmd.we) begin
			if (cmd.kind == rccs_pkg::KIND_BEGIN) begin
				for (int i = 0; i < rccs_pkg::CHANNELS; i++) begin
					low_q[i]  <= rccs_pkg::CAL_LOW_START;
					high_q[i] <= rccs_pkg::CAL_HIGH_START;
				end
			end else begin
				low_q[cmd.ch]  <= rd.new_lo;
				high_q[cmd.ch] <= rd.new_hi;
			end
		end
	end

endmodule
